// ----- rtl/jise_pkg.sv -----
// Shared constants, types and decode helpers for the integer stack executor.
// Used by every module of the block except jise_ram; depends on nothing.
package jise_pkg;

  // Sizes of the operand stack and the locals bank
  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_COUNT = 256;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int LA_W = $clog2(LOCAL_COUNT);

  // Opcodes handled
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_ICONST_M = 8'h02;
  localparam logic [7:0] OP_ICONST_5 = 8'h08;
  localparam logic [7:0] OP_LCONST_0 = 8'h09;
  localparam logic [7:0] OP_LCONST_1 = 8'h0a;
  localparam logic [7:0] OP_BIPUSH   = 8'h10;
  localparam logic [7:0] OP_LLOAD    = 8'h16;
  localparam logic [7:0] OP_ILOAD_0  = 8'h1a;
  localparam logic [7:0] OP_ILOAD_2  = 8'h1c;
  localparam logic [7:0] OP_ISTORE   = 8'h36;
  localparam logic [7:0] OP_LSTORE   = 8'h37;
  localparam logic [7:0] OP_ISTORE_0 = 8'h3b;
  localparam logic [7:0] OP_ISTORE_3 = 8'h3e;
  localparam logic [7:0] OP_IADD     = 8'h60;
  localparam logic [7:0] OP_LADD     = 8'h61;
  localparam logic [7:0] OP_IMUL     = 8'h68;
  localparam logic [7:0] OP_LMUL     = 8'h69;
  localparam logic [7:0] OP_IDIV     = 8'h6c;

  // Operation kinds after decode
  localparam logic [3:0] K_NOP    = 4'd0;
  localparam logic [3:0] K_CONST  = 4'd1;
  localparam logic [3:0] K_ILOAD  = 4'd2;
  localparam logic [3:0] K_LLOAD  = 4'd3;
  localparam logic [3:0] K_ISTORE = 4'd4;
  localparam logic [3:0] K_LSTORE = 4'd5;
  localparam logic [3:0] K_IADD   = 4'd6;
  localparam logic [3:0] K_LADD   = 4'd7;
  localparam logic [3:0] K_IMUL   = 4'd8;
  localparam logic [3:0] K_LMUL   = 4'd9;
  localparam logic [3:0] K_IDIV   = 4'd10;
  localparam logic [3:0] K_BAD    = 4'd11;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNSUP  = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_DIVZ   = 3'd4;
  localparam logic [2:0] ST_BADIDX = 3'd5;

  // Accumulator operations for the multiply sequence
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADDH = 2'd2;

  // Partial product selects
  localparam logic [1:0] MS_LL = 2'd0;
  localparam logic [1:0] MS_LH = 2'd1;
  localparam logic [1:0] MS_HL = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  pops;
    logic        pushes;
    logic        uses_idx;
    logic [7:0]  idx;
    logic [63:0] cval;
  } dec_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       latch;     // capture input beat
    logic       check;     // record status of the captured item
    logic       push;      // write at sp, sp+1
    logic       popush;    // write result at sp-2, sp-1
    logic       rd_next;   // stack read at sp-2
    logic       take_next; // capture next operand
    logic       store;     // local write, sp-1, stack read at sp-2
    logic       take_top;  // capture new top from stack
    logic       ld_read;   // local read
    logic       mul_go;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] err;
    logic       div_done;
  } sts_t;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic dec_t jise_decode(input logic [7:0] op, input logic [7:0] imm);
    dec_t d;
    d = '0;
    d.kind = K_BAD;
    if (op == OP_NOP) begin
      d.kind = K_NOP;
    end else if (op >= OP_ICONST_M && op <= OP_ICONST_5) begin
      d.kind = K_CONST; d.pushes = 1'b1;
      d.cval = {56'd0, op} - 64'd3;
    end else if (op == OP_LCONST_0 || op == OP_LCONST_1) begin
      d.kind = K_CONST; d.pushes = 1'b1;
      d.cval = {56'd0, op} - 64'd9;
    end else if (op == OP_BIPUSH) begin
      d.kind = K_CONST; d.pushes = 1'b1;
      d.cval = {{56{imm[7]}}, imm};
    end else if (op == OP_LLOAD) begin
      d.kind = K_LLOAD; d.pushes = 1'b1; d.idx = imm; d.uses_idx = 1'b1;
    end else if (op >= OP_ILOAD_0 && op <= OP_ILOAD_2) begin
      d.kind = K_ILOAD; d.pushes = 1'b1; d.idx = op - OP_ILOAD_0; d.uses_idx = 1'b1;
    end else if (op == OP_ISTORE) begin
      d.kind = K_ISTORE; d.pops = 2'd1; d.idx = imm; d.uses_idx = 1'b1;
    end else if (op == OP_LSTORE) begin
      d.kind = K_LSTORE; d.pops = 2'd1; d.idx = imm; d.uses_idx = 1'b1;
    end else if (op >= OP_ISTORE_0 && op <= OP_ISTORE_3) begin
      d.kind = K_ISTORE; d.pops = 2'd1; d.idx = op - OP_ISTORE_0; d.uses_idx = 1'b1;
    end else if (op == OP_IADD) begin
      d.kind = K_IADD; d.pops = 2'd2; d.pushes = 1'b1;
    end else if (op == OP_LADD) begin
      d.kind = K_LADD; d.pops = 2'd2; d.pushes = 1'b1;
    end else if (op == OP_IMUL) begin
      d.kind = K_IMUL; d.pops = 2'd2; d.pushes = 1'b1;
    end else if (op == OP_LMUL) begin
      d.kind = K_LMUL; d.pops = 2'd2; d.pushes = 1'b1;
    end else if (op == OP_IDIV) begin
      d.kind = K_IDIV; d.pops = 2'd2; d.pushes = 1'b1;
    end
    return d;
  endfunction

endpackage

// ----- rtl/jise_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jise_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/jise_div.sv -----
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// Depends on jise_pkg only for house conventions; quotient truncates toward zero.
module jise_div
  import jise_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] mb;
  logic        neg;
  logic [32:0] trial;

  // trial subtraction of the shifted remainder
  assign trial = {rem, q[31]} - {1'b0, mb};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 5'd31;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // magnitudes and iteration
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[31] ? (32'd0 - dividend) : dividend;
      mb  <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem <= '0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], q[31]};
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  assign quot = neg ? (32'd0 - q) : q;

endmodule

// ----- rtl/jise_ctrl.sv -----
// Sequencing controller for the stack executor: one item at a time.
// Depends on jise_pkg; drives the datapath through cmd_t, reads sts_t.
module jise_ctrl
  import jise_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LDW  = 4'd2;
  localparam logic [3:0] S_RTOP = 4'd3;
  localparam logic [3:0] S_RNXT = 4'd4;
  localparam logic [3:0] S_OPS  = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_MUL3 = 4'd8;
  localparam logic [3:0] S_DIVW = 4'd9;
  localparam logic [3:0] S_WB   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.check = 1'b1;
        if (sts.err != ST_OK) begin
          state_next = S_DONE;
        end else begin
          priority case (sts.kind)
            K_CONST: begin
              cmd.push = 1'b1; state_next = S_DONE;
            end
            K_ILOAD, K_LLOAD: begin
              cmd.ld_read = 1'b1; state_next = S_LDW;
            end
            K_ISTORE, K_LSTORE: begin
              cmd.store = 1'b1; state_next = S_RTOP;
            end
            K_IADD, K_LADD, K_IMUL, K_LMUL, K_IDIV: begin
              cmd.rd_next = 1'b1; state_next = S_RNXT;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_LDW: begin
        cmd.push = 1'b1; state_next = S_DONE;
      end
      S_RTOP: begin
        cmd.take_top = 1'b1; state_next = S_DONE;
      end
      S_RNXT: begin
        cmd.take_next = 1'b1; state_next = S_OPS;
      end
      S_OPS: begin
        if (sts.kind == K_IMUL || sts.kind == K_LMUL) begin
          cmd.mul_go = 1'b1; cmd.mul_sel = MS_LL; state_next = S_MUL1;
        end else if (sts.kind == K_IDIV) begin
          cmd.div_start = 1'b1; state_next = S_DIVW;
        end else begin
          state_next = S_WB;
        end
      end
      S_MUL1: begin
        cmd.mul_go = 1'b1; cmd.mul_sel = MS_LH; cmd.acc_op = ACC_LOAD;
        state_next = (sts.kind == K_LMUL) ? S_MUL2 : S_WB;
      end
      S_MUL2: begin
        cmd.mul_go = 1'b1; cmd.mul_sel = MS_HL; cmd.acc_op = ACC_ADDH;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_op = ACC_ADDH; state_next = S_WB;
      end
      S_DIVW: begin
        if (sts.div_done) state_next = S_WB;
      end
      S_WB: begin
        cmd.popush = 1'b1; state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !in_stall) else $error("stall raised while idle");
  a_accept_dec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DEC)) else $error("accept did not decode");
  a_load_sets: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result beat not raised");
`endif

endmodule

// ----- rtl/jise_dp.sv -----
// Datapath of the stack executor: stack and locals RAMs, top register,
// multiply accumulator, divider and result registers. Depends on jise_pkg,
// jise_ram and jise_div.
module jise_dp
  import jise_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         opcode,
  input  logic [7:0]         operand_byte,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic signed [63:0] top_value,
  output logic [4:0]         stack_depth,
  output logic [2:0]         status
);

  logic [7:0]             op_r;
  logic [7:0]             imm_r;
  logic [SP_W-1:0]        sp;
  logic [63:0]            top_r;
  logic [63:0]            nxt_r;
  logic [63:0]            prod_r;
  logic [63:0]            acc;
  logic [2:0]             status_r;
  logic [LOCAL_COUNT-1:0] lvalid;
  logic                   lvalid_r;
  dec_t                   dec;
  logic [2:0]             err;
  logic [SP_W:0]          depth_after;
  logic [SA_W-1:0]        sa_m2;
  logic [LA_W-1:0]        la;
  logic [63:0]            st_rdata;
  logic [63:0]            lo_rdata;
  logic [63:0]            ld_val;
  logic [63:0]            push_val;
  logic [63:0]            res;
  logic                   st_we;
  logic [SA_W-1:0]        st_waddr;
  logic [63:0]            st_wdata;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic                   div_done;
  logic [31:0]            div_q;

  assign dec   = jise_decode(op_r, imm_r);
  assign sa_m2 = SA_W'(sp - SP_W'(2));
  assign la    = dec.idx[LA_W-1:0];

  // error checks in priority order
  assign depth_after = {1'b0, sp} - (SP_W+1)'(dec.pops) + (SP_W+1)'(dec.pushes);
  always_comb begin
    if (dec.kind == K_BAD)
      err = ST_UNSUP;
    else if ({1'b0, sp} < (SP_W+1)'(dec.pops))
      err = ST_UNDER;
    else if (depth_after > (SP_W+1)'(STACK_DEPTH))
      err = ST_OVER;
    else if (dec.uses_idx && {1'b0, dec.idx} >= 9'(LOCAL_COUNT))
      err = ST_BADIDX;
    else if (dec.kind == K_IDIV && top_r[31:0] == 32'd0)
      err = ST_DIVZ;
    else
      err = ST_OK;
  end

  assign sts.kind     = dec.kind;
  assign sts.err      = err;
  assign sts.div_done = div_done;

  // value from a local; never-written locals read as zero
  assign ld_val   = lvalid_r ? ((dec.kind == K_ILOAD) ? sext32(lo_rdata) : lo_rdata) : 64'd0;
  assign push_val = (dec.kind == K_CONST) ? dec.cval : ld_val;

  // result of a two-operand op
  always_comb begin
    unique case (dec.kind)
      K_IADD:  res = sext32(nxt_r + top_r);
      K_LADD:  res = nxt_r + top_r;
      K_IMUL:  res = sext32(acc);
      K_LMUL:  res = acc;
      K_IDIV:  res = sext32({32'd0, div_q});
      default: res = 64'd0;
    endcase
  end

  // stack RAM port muxing
  assign st_we    = cmd.push || cmd.popush;
  assign st_waddr = cmd.push ? sp[SA_W-1:0] : sa_m2;
  assign st_wdata = cmd.push ? push_val : res;

  jise_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.rd_next || cmd.store),
    .raddr (sa_m2),
    .rdata (st_rdata)
  );

  jise_ram #(.WIDTH(64), .DEPTH(LOCAL_COUNT)) u_locals (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (la),
    .wdata ((dec.kind == K_ISTORE) ? sext32(top_r) : top_r),
    .re    (cmd.ld_read),
    .raddr (la),
    .rdata (lo_rdata)
  );

  jise_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (nxt_r[31:0]),
    .divisor  (top_r[31:0]),
    .done     (div_done),
    .quot     (div_q)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= opcode;
      imm_r <= operand_byte;
    end
  end

  // stack pointer and local valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sp     <= '0;
      lvalid <= '0;
    end else begin
      if (cmd.push) sp <= sp + SP_W'(1);
      else if (cmd.popush || cmd.store) sp <= sp - SP_W'(1);
      if (cmd.store) lvalid[la] <= 1'b1;
    end
  end

  // top and next operand
  always_ff @(posedge clk) begin
    if (cmd.push) top_r <= push_val;
    else if (cmd.popush) top_r <= res;
    else if (cmd.take_top) top_r <= st_rdata;
    if (cmd.take_next) nxt_r <= st_rdata;
    if (cmd.ld_read) lvalid_r <= lvalid[la];
  end

  // multiply: one 32x32 product a cycle, registered, then accumulated
  always_comb begin
    unique case (cmd.mul_sel)
      MS_LH:   begin mul_a = nxt_r[31:0];  mul_b = top_r[63:32]; end
      MS_HL:   begin mul_a = nxt_r[63:32]; mul_b = top_r[31:0];  end
      default: begin mul_a = nxt_r[31:0];  mul_b = top_r[31:0];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
    unique case (cmd.acc_op)
      ACC_LOAD: acc <= prod_r;
      ACC_ADDH: acc[63:32] <= acc[63:32] + prod_r[31:0];
      default:  acc <= acc;
    endcase
  end

  // status and result beat
  always_ff @(posedge clk) begin
    if (cmd.check) status_r <= err;
    if (cmd.out_load) begin
      top_value   <= (sp == '0) ? 64'sd0 : $signed(top_r);
      stack_depth <= 5'(sp);
      status      <= status_r;
    end
  end

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (sp < SP_W'(STACK_DEPTH))) else $error("push onto full stack");
  a_pop_two: assert property (@(posedge clk) disable iff (rst)
    cmd.popush |-> (sp >= SP_W'(2))) else $error("binary op with too few slots");
  a_store_one: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (sp != '0)) else $error("store from empty stack");
`endif

endmodule

// ----- rtl/jvm_integer_stack_executor_core.sv -----
// Top level of the integer stack executor: controller plus datapath.
// Depends on jise_pkg, jise_ctrl and jise_dp (with jise_ram and jise_div).
//
// One bytecode per input beat, one result beat per item. Items are handled one
// at a time; each follows the controller's state sequence: decode, then a stack
// or locals access for pushes, loads and stores, an operand read for two-operand
// ops, the multiply steps for imul and lmul, the divider run for idiv (the divider
// retires one quotient bit a cycle), write-back, and a wait in the done state
// while out_stall holds the output register. A new beat is taken once the previous
// result has been placed in the output register. The locals read as zero after
// reset through per-entry valid bits, so no clearing pass is needed.
module jvm_integer_stack_executor_core
  import jise_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         opcode,
  input  logic [7:0]         operand_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] top_value,
  output logic [4:0]         stack_depth,
  output logic [2:0]         status
);

  cmd_t cmd;
  sts_t sts;

  jise_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  jise_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .operand_byte (operand_byte),
    .cmd          (cmd),
    .sts          (sts),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .status       (status)
  );

endmodule
